/* rtl/core/qenc_pkg.sv */
// ----------------------------------------------------------------------------
// qenc_pkg
// Shared types and constants for the quadrature encoder with speed unit.
// ----------------------------------------------------------------------------
package qenc_pkg;

    localparam int unsigned TIME_W  = 32;
    localparam int unsigned POS_W   = 31;
    localparam int unsigned DIR_W   = 2;
    localparam int unsigned IVL_W   = 23;
    localparam int unsigned RPM_W   = 26;
    localparam int unsigned MODE_W  = 2;
    localparam int unsigned SPR_W   = 8;
    localparam int unsigned CFG_W   = 8;

    localparam logic [MODE_W-1:0] MODE_PINS3 = 2'd0;
    localparam logic [MODE_W-1:0] MODE_PINS0 = 2'd1;
    localparam logic [MODE_W-1:0] MODE_BOTH  = 2'd2;
    localparam logic [MODE_W-1:0] MODE_NONE  = 2'd3;

    localparam logic CFG_LATCH_MODE = 1'b0;
    localparam logic CFG_STEPS      = 1'b1;

    localparam logic [DIR_W-1:0] DIR_NONE = 2'd0;
    localparam logic [DIR_W-1:0] DIR_CW   = 2'd1;
    localparam logic [DIR_W-1:0] DIR_CCW  = 2'd2;

    localparam logic [TIME_W-1:0] RPM_NUMERATOR = 32'd60000000;
    localparam logic [SPR_W-1:0]  SPR_RESET     = 8'd20;

    // Microseconds to milliseconds: floor(x / 1000) equals
    // (x * MS_RECIP) >> MS_SHIFT for every 32-bit x.
    localparam logic [TIME_W-1:0] MS_RECIP = 32'd274877907;
    localparam int unsigned       MS_SHIFT = 38;

    // Work handed from the front part to the back part through the one-entry job register.
    typedef struct packed {
        logic [POS_W-1:0]  position;
        logic [DIR_W-1:0]  direction;
        logic              detent_event;
        logic [TIME_W-1:0] delta_time;
        logic [39:0]       interval_sum;
        logic [6:0]        ring_fill;
        logic [SPR_W-1:0]  steps_per_rev;
    } t_job;

    typedef struct packed {
        logic [POS_W-1:0] position;
        logic [DIR_W-1:0] direction;
        logic             detent_event;
        logic [IVL_W-1:0] interval_ms;
        logic [RPM_W-1:0] speed_rpm;
    } t_result;

    function automatic logic [1:0] step_dir(input logic [3:0] idx);
        // Bit 0: move, bit 1: backward.
        logic [1:0] r;
        unique case (idx)
            4'd1, 4'd7, 4'd8, 4'd14: r = 2'b11;
            4'd2, 4'd4, 4'd11, 4'd13: r = 2'b01;
            default:                  r = 2'b00;
        endcase
        return r;
    endfunction

endpackage

/* rtl/core/qenc_front.sv */
// ----------------------------------------------------------------------------
// qenc_front
// Decodes pin samples, tracks detent timing and the interval ring, and hands
// one job per sample to the back part.
// ----------------------------------------------------------------------------
module qenc_front #(
    parameter int unsigned RING_DEPTH = 8
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic                           i_level_a,
    input  logic                           i_level_b,
    input  logic [qenc_pkg::TIME_W-1:0]    i_time_us,
    input  logic                           i_take_direction,
    input  logic [qenc_pkg::MODE_W-1:0]    i_latch_mode,
    input  logic [qenc_pkg::SPR_W-1:0]     i_steps_per_rev,
    output logic                           o_job_valid,
    input  logic                           i_job_ready,
    output qenc_pkg::t_job                 o_job
);
    import qenc_pkg::*;

    localparam int unsigned SLOT_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;

    logic [TIME_W-1:0] r_ring [RING_DEPTH];
    logic [SLOT_W-1:0] r_slot;
    logic [6:0]        r_fill;
    logic [39:0]       r_sum;
    logic              r_primed;
    logic [1:0]        r_prev;
    logic [31:0]       r_steps;
    logic [POS_W-1:0]  r_held;
    logic [POS_W-1:0]  r_ack;
    logic [TIME_W-1:0] r_last;
    logic [TIME_W-1:0] r_prior;
    logic              r_job_valid;
    t_job              r_job;

    logic [1:0]        pins;
    logic [1:0]        sd;
    logic              detent;
    logic [31:0]       n_steps;
    logic [TIME_W-1:0] diff;
    logic [POS_W-1:0]  n_held;
    logic [TIME_W-1:0] n_last;
    logic [TIME_W-1:0] n_prior;
    logic [39:0]       n_sum;
    logic [6:0]        n_fill;
    logic              ev;
    logic              accept;

    assign pins   = {i_level_b, i_level_a};
    assign o_ready = !r_job_valid || i_job_ready;
    assign accept = i_valid && o_ready;
    assign sd     = step_dir({r_prev, pins});
    assign diff   = i_time_us - r_last;

    always_comb begin
        unique case (i_latch_mode)
            MODE_PINS3: detent = (pins == 2'd3);
            MODE_PINS0: detent = (pins == 2'd0);
            MODE_BOTH:  detent = (pins == 2'd0) || (pins == 2'd3);
            MODE_NONE:  detent = 1'b0;
            default:    detent = 1'b0;
        endcase
    end

    always_comb begin
        n_steps = r_steps;
        n_held  = r_held;
        n_last  = r_last;
        n_prior = r_prior;
        n_sum   = r_sum;
        n_fill  = r_fill;
        ev      = 1'b0;
        if (!r_primed) begin
            n_last  = i_time_us;
            n_prior = i_time_us;
        end else if (pins != r_prev) begin
            n_steps = r_steps + (sd[0] ? (sd[1] ? 32'hFFFF_FFFF : 32'd1) : 32'd0);
            if (detent) begin
                ev      = 1'b1;
                n_sum   = r_sum - {8'd0, r_ring[r_slot]} + {8'd0, diff};
                n_fill  = (r_fill < 7'(RING_DEPTH)) ? r_fill + 7'd1 : r_fill;
                n_held  = (i_latch_mode == MODE_BOTH) ? n_steps[31:1]
                        : {n_steps[31], n_steps[31:2]};
                n_prior = r_last;
                n_last  = i_time_us;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_primed    <= 1'b0;
            r_prev      <= 2'd0;
            r_steps     <= '0;
            r_held      <= '0;
            r_ack       <= '0;
            r_last      <= '0;
            r_prior     <= '0;
            r_slot      <= '0;
            r_fill      <= '0;
            r_sum       <= '0;
            r_job_valid <= 1'b0;
            for (int i = 0; i < int'(RING_DEPTH); i++) begin
                r_ring[i] <= '0;
            end
        end else begin
            if (accept) begin
                r_primed    <= 1'b1;
                r_prev      <= pins;
                r_steps     <= n_steps;
                r_held      <= n_held;
                r_last      <= n_last;
                r_prior     <= n_prior;
                r_sum       <= n_sum;
                r_fill      <= n_fill;
                r_job_valid <= 1'b1;
                if (ev) begin
                    r_ring[r_slot] <= diff;
                    r_slot <= (r_slot == SLOT_W'(RING_DEPTH - 1)) ? '0 : r_slot + 1'b1;
                end
                if (i_take_direction) begin
                    r_ack <= n_held;
                end
            end else if (i_job_ready) begin
                r_job_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_job.position      <= n_held;
            r_job.direction     <= ($signed(n_held) > $signed(r_ack)) ? DIR_CW
                                 : ($signed(n_held) < $signed(r_ack)) ? DIR_CCW : DIR_NONE;
            r_job.detent_event  <= ev;
            r_job.delta_time    <= n_last - n_prior;
            r_job.interval_sum  <= n_sum;
            r_job.ring_fill     <= n_fill;
            r_job.steps_per_rev <= i_steps_per_rev;
        end
    end

    assign o_job_valid = r_job_valid;
    assign o_job       = r_job;
endmodule

/* rtl/core/qenc_divider.sv */
// ----------------------------------------------------------------------------
// qenc_divider
// Restoring serial divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module qenc_divider #(
    parameter int unsigned WIDTH = 40
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [WIDTH-1:0] i_dividend,
    input  logic [WIDTH-1:0] i_divisor,
    output logic             o_done,
    output logic [WIDTH-1:0] o_quotient
);
    localparam int unsigned CNT_W = $clog2(WIDTH + 1);

    logic [WIDTH-1:0] r_q;
    logic [WIDTH-1:0] r_rem;
    logic [WIDTH-1:0] r_div;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;
    logic [WIDTH:0]   trial;

    assign trial = {r_rem, r_q[WIDTH-1]} - {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(WIDTH);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            if (!trial[WIDTH]) begin
                r_rem <= trial[WIDTH-1:0];
                r_q   <= {r_q[WIDTH-2:0], 1'b1};
            end else begin
                r_rem <= {r_rem[WIDTH-2:0], r_q[WIDTH-1]};
                r_q   <= {r_q[WIDTH-2:0], 1'b0};
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_q;
endmodule

/* rtl/core/qenc_back.sv */
// ----------------------------------------------------------------------------
// qenc_back
// Converts the interval to ms, sequences the average and RPM divisions of one
// job and holds the finished result.
// ----------------------------------------------------------------------------
module qenc_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_job_valid,
    output logic                 o_job_ready,
    input  qenc_pkg::t_job       i_job,
    output logic                 o_res_valid,
    input  logic                 i_res_ready,
    output qenc_pkg::t_result    o_res
);
    import qenc_pkg::*;

    localparam int unsigned DW = 40;
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MS   = 3'd1;
    localparam logic [2:0] S_AVG  = 3'd2;
    localparam logic [2:0] S_MUL  = 3'd3;
    localparam logic [2:0] S_RPM  = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;

    logic [2:0]       r_state;
    logic [2:0]       n_state;
    t_job             r_job;
    t_result          r_res;
    logic [DW-1:0]    r_avg;
    logic [DW-1:0]    r_den;
    logic             r_start;
    logic [DW-1:0]    r_dividend;
    logic [DW-1:0]    r_divisor;
    logic             done;
    logic [DW-1:0]    quo;
    logic [2*TIME_W-1:0] ms_prod;
    logic [DW-1:0]    den;

    qenc_divider #(.WIDTH(DW)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_start),
        .i_dividend (r_dividend),
        .i_divisor  (r_divisor),
        .o_done     (done),
        .o_quotient (quo)
    );

    // The average never exceeds one 32-bit interval.
    assign ms_prod     = r_job.delta_time * MS_RECIP;
    assign den         = r_avg[TIME_W-1:0] * r_job.steps_per_rev;

    assign o_job_ready = (r_state == S_IDLE);
    assign o_res_valid = (r_state == S_OUT);
    assign o_res       = r_res;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (i_job_valid) n_state = S_MS;
            S_MS:   n_state = S_AVG;
            S_AVG:  if (done) n_state = S_MUL;
            S_MUL:  n_state = S_RPM;
            S_RPM:  if (done || r_den == '0) n_state = S_OUT;
            S_OUT:  if (i_res_ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_start <= 1'b0;
        end else begin
            r_state <= n_state;
            unique case (r_state)
                S_MS:   r_start <= 1'b1;
                S_MUL:  r_start <= (den != '0);
                default: r_start <= 1'b0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                r_job      <= i_job;
            end
            S_MS: begin
                r_res.interval_ms <= ms_prod[MS_SHIFT +: IVL_W];
                r_dividend        <= r_job.interval_sum;
                r_divisor         <= {33'd0, r_job.ring_fill};
            end
            S_AVG: if (done) begin
                r_avg <= (r_job.ring_fill == '0) ? '0 : quo;
            end
            S_MUL: begin
                r_den      <= den;
                r_divisor  <= den;
                r_dividend <= {8'd0, RPM_NUMERATOR};
            end
            S_RPM: begin
                r_res.position     <= r_job.position;
                r_res.direction    <= r_job.direction;
                r_res.detent_event <= r_job.detent_event;
                r_res.speed_rpm    <= (r_den == '0) ? '0 : quo[RPM_W-1:0];
            end
            default: ;
        endcase
    end
endmodule

/* rtl/core/quadrature_encoder_with_speed_unit.sv */
// ----------------------------------------------------------------------------
// quadrature_encoder_with_speed_unit
// Quadrature decoder with detent position, interval and averaged RPM.
// ----------------------------------------------------------------------------
// Each pushed pin sample yields one result. The front part decodes a sample
// and registers it in a one-entry register that passes it to the back part,
// which turns the detent interval into ms with a reciprocal multiply and then
// runs two 40-bit serial divisions on one shared divider (ring average, RPM);
// the RPM division is skipped when its divisor is zero, and the divisions set
// the rate unless a result waits to be popped. The front part takes the next
// sample while that runs.
module quadrature_encoder_with_speed_unit #(
    parameter int unsigned RING_DEPTH = 8
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             push,
    output logic                             full,
    input  logic                             i_level_a,
    input  logic                             i_level_b,
    input  logic [qenc_pkg::TIME_W-1:0]      i_time_us,
    input  logic                             i_take_direction,
    output logic                             empty,
    input  logic                             pop,
    output logic signed [qenc_pkg::POS_W-1:0] o_detent_position,
    output logic [qenc_pkg::DIR_W-1:0]       o_direction,
    output logic                             o_detent_event,
    output logic [qenc_pkg::IVL_W-1:0]       o_interval_ms,
    output logic [qenc_pkg::RPM_W-1:0]       o_speed_rpm,
    input  logic                             i_cfg_we,
    input  logic                             i_cfg_index,
    input  logic [qenc_pkg::CFG_W-1:0]       i_cfg_data
);
    import qenc_pkg::*;

    logic [MODE_W-1:0] r_latch_mode;
    logic [SPR_W-1:0]  r_steps_per_rev;
    logic              ready;
    logic              job_valid;
    logic              job_ready;
    t_job              job;
    logic              res_valid;
    t_result           res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_latch_mode    <= MODE_PINS3;
            r_steps_per_rev <= SPR_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_LATCH_MODE: r_latch_mode    <= i_cfg_data[MODE_W-1:0];
                CFG_STEPS:      r_steps_per_rev <= i_cfg_data;
                default: ;
            endcase
        end
    end

    qenc_front #(.RING_DEPTH(RING_DEPTH)) u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (push),
        .o_ready          (ready),
        .i_level_a        (i_level_a),
        .i_level_b        (i_level_b),
        .i_time_us        (i_time_us),
        .i_take_direction (i_take_direction),
        .i_latch_mode     (r_latch_mode),
        .i_steps_per_rev  (r_steps_per_rev),
        .o_job_valid      (job_valid),
        .i_job_ready      (job_ready),
        .o_job            (job)
    );

    qenc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (job_valid),
        .o_job_ready (job_ready),
        .i_job       (job),
        .o_res_valid (res_valid),
        .i_res_ready (pop),
        .o_res       (res)
    );

    assign full              = !ready;
    assign empty             = !res_valid;
    assign o_detent_position = res.position;
    assign o_direction       = res.direction;
    assign o_detent_event    = res.detent_event;
    assign o_interval_ms     = res.interval_ms;
    assign o_speed_rpm       = res.speed_rpm;
endmodule
